// ----- src/gbp_pkg.sv -----
// Types and constants shared by the gshare branch predictor.
package gbp_pkg;

	// Configuration register widths and indexes
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_BITS = 1'd1;

	localparam logic [CFG_W-1:0] INDEX_BITS_RST   = 4'd12;
	localparam logic [CFG_W-1:0] HISTORY_BITS_RST = 4'd8;

	// Opcodes
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 32;

	// Request item
	typedef struct packed {
		logic              opcode;
		logic [ADDR_W-1:0] branch_address;
		logic              actual_taken;
	} gbp_req_t;

	// Result item
	typedef struct packed {
		logic               predicted_taken;
		logic               prediction_correct;
		logic [COUNT_W-1:0] prediction_count;
		logic [COUNT_W-1:0] misprediction_count;
	} gbp_rsp_t;

endpackage

// ----- src/gshare_branch_predictor.sv -----
// Gshare branch predictor with one-bit pattern table and saturating counters.
// Pipeline: stage 1 input register, stage 2 prediction, output register.
// Throughput: one item per cycle unless stalled, one table read-modify-write per cycle.
// Reset: counters, history and config go to reset values at once; then a
// clearing pass writes taken into all 2^MAX_INDEX_BITS table entries, with
// req_stall held high. Config writes are taken throughout.
module gshare_branch_predictor
	import gbp_pkg::*;
#(
	parameter int MAX_INDEX_BITS = 12,
	parameter int ADDRESS_BITS   = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	// request channel
	input  logic                 req_valid,
	output logic                 req_stall,
	input  gbp_req_t             req,
	// result channel
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output gbp_rsp_t             rsp
);

	localparam int MI    = MAX_INDEX_BITS;
	localparam int DEPTH = 1 << MI;
	// address bits that can ever reach the index
	localparam int ADDR_LIM = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
	localparam int ADDR_USE = (ADDR_LIM < MI + 2) ? ADDR_LIM : MI + 2;
	localparam int AW       = ADDR_USE - 2;
	// width for index and history lengths
	localparam int IBW = $clog2(MI + 1);
	localparam int SW  = (IBW > CFG_W) ? IBW : CFG_W;

	// low n bits set, n up to MI
	function automatic logic [MI-1:0] low_mask(input logic [SW-1:0] n);
		logic [MI-1:0] ones;
		ones = '1;
		return ~(ones << n);
	endfunction

	// configuration registers
	logic [CFG_W-1:0] index_bits_q;
	logic [CFG_W-1:0] history_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q   <= INDEX_BITS_RST;
			history_bits_q <= HISTORY_BITS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INDEX_BITS:   index_bits_q   <= cfg_wdata;
				CFG_HISTORY_BITS: history_bits_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic valid_s1, valid_s2, out_free, s2_free, s1_move, s2_move, s1_free;
	logic clearing_q;
	logic [MI-1:0] clr_cnt_q;

	assign out_free  = !rsp_valid || !rsp_stall;
	assign s2_free   = !valid_s2 || out_free;
	assign s2_move   = valid_s2 && out_free;
	assign s1_move   = valid_s1 && s2_free;
	assign s1_free   = !valid_s1 || s2_free;
	assign req_stall = clearing_q || !s1_free;

	// stage 1: input register
	logic          op_s1, actual_s1;
	logic [AW-1:0] addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= req_valid && !clearing_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			op_s1     <= req.opcode;
			actual_s1 <= req.actual_taken;
			addr_s1   <= req.branch_address[ADDR_USE-1:2];
		end
	end

	// effective index and history lengths
	logic [SW-1:0] cfg_ib, cfg_h, ib_eff, h_eff, lowlen;
	always_comb begin
		cfg_ib = SW'(index_bits_q);
		cfg_h  = SW'(history_bits_q);
		if (cfg_ib == '0) begin
			ib_eff = SW'(1);
		end else if (cfg_ib > SW'(MI)) begin
			ib_eff = SW'(MI);
		end else begin
			ib_eff = cfg_ib;
		end
		h_eff  = (cfg_h > ib_eff) ? ib_eff : cfg_h;
		lowlen = ib_eff - h_eff;
	end

	// table index: upper h bits of the masked address hashed with history
	logic [MI-1:0] history_q;
	logic [MI-1:0] base, hist_m, hashed, idx_s1, hist_next;
	always_comb begin
		base   = MI'(addr_s1) & low_mask(ib_eff);
		hist_m = history_q & low_mask(h_eff);
		hashed = (hist_m ^ (base >> lowlen)) & low_mask(h_eff);
		if (h_eff == '0) begin
			idx_s1 = base;
		end else begin
			idx_s1 = (hashed << lowlen) | (base & low_mask(lowlen));
		end
		hist_next = ((hist_m >> 1) | (MI'(actual_s1) << (h_eff - SW'(1))))
			& low_mask(h_eff);
	end

	// global history: shifted as an update item leaves stage 1, if the history length is not zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q <= '0;
		end else if (s1_move && op_s1 == OP_UPDATE && h_eff != '0) begin
			history_q <= hist_next;
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + MI'(1);
			if (clr_cnt_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// pattern table, single port, read-first
	logic          tbl [DEPTH];
	logic [MI-1:0] mem_addr;
	logic          mem_we, mem_wdata, rdata_s2;

	always_comb begin
		if (clearing_q) begin
			mem_addr  = clr_cnt_q;
			mem_we    = 1'b1;
			mem_wdata = 1'b1;
		end else begin
			mem_addr  = idx_s1;
			mem_we    = s1_move && op_s1 == OP_UPDATE;
			mem_wdata = actual_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl[mem_addr] <= mem_wdata;
		end
		if (s1_move) begin
			rdata_s2 <= tbl[mem_addr];
		end
	end

	// stage 2: prediction available
	logic op_s2, actual_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_move;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			op_s2     <= op_s1;
			actual_s2 <= actual_s1;
		end
	end

	// saturating counters
	logic [COUNT_W-1:0] pred_cnt_q, mis_cnt_q, pred_cnt_next, mis_cnt_next;
	logic               is_update, wrong;
	always_comb begin
		is_update     = op_s2 == OP_UPDATE;
		wrong         = is_update && (rdata_s2 != actual_s2);
		pred_cnt_next = (is_update && pred_cnt_q != '1) ? pred_cnt_q + COUNT_W'(1)
			: pred_cnt_q;
		mis_cnt_next  = (wrong && mis_cnt_q != '1) ? mis_cnt_q + COUNT_W'(1)
			: mis_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_cnt_q <= '0;
			mis_cnt_q  <= '0;
		end else if (s2_move) begin
			pred_cnt_q <= pred_cnt_next;
			mis_cnt_q  <= mis_cnt_next;
		end
	end

	// output register
	logic     rsp_valid_q;
	gbp_rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			rsp_q.predicted_taken     <= rdata_s2;
			rsp_q.prediction_correct  <= !wrong;
			rsp_q.prediction_count    <= pred_cnt_next;
			rsp_q.misprediction_count <= mis_cnt_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> req_stall)
		else $error("item accepted during table clearing");

	a_query_correct: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_move && op_s2 == OP_QUERY) |=> rsp_q.prediction_correct)
		else $error("query reported a misprediction");

	a_mis_le_pred: assert property (@(posedge clk) disable iff (!arst_n)
		mis_cnt_q <= pred_cnt_q)
		else $error("misprediction count above prediction count");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s2_move |=> ($stable(pred_cnt_q) && $stable(mis_cnt_q)))
		else $error("counter changed with no item leaving stage 2");

endmodule

// ----- tb/gbp_result_check.sv -----
// Predictor model and result comparison for the gshare branch predictor testbench.
module gbp_result_check
	import gbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  gbp_req_t             req,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  gbp_rsp_t             rsp,
	output int                   fails,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOT_BITS = 12;
	localparam int SLOTS     = 1 << SLOT_BITS;

	// Model state: one outcome bit per slot, global history, totals, config
	logic [SLOTS-1:0]     outcome_table;
	logic [SLOT_BITS-1:0] ghist;
	logic [COUNT_W-1:0]   update_total;
	logic [COUNT_W-1:0]   miss_total;
	logic [CFG_W-1:0]     index_width;
	logic [CFG_W-1:0]     hist_width;

	gbp_rsp_t expected_rsps[$];

	// Table slot: address bits above the byte offset, top h bits hashed with history
	function automatic logic [SLOT_BITS-1:0] table_slot(input logic [ADDR_W-1:0] addr,
			input int ib, input int h);
		logic [SLOT_BITS-1:0] base;
		logic [SLOT_BITS-1:0] hmask;
		logic [SLOT_BITS-1:0] lmask;
		int lowlen;
		base = SLOT_BITS'((addr >> 2) & ((32'd1 << ib) - 32'd1));
		if (h == 0)
			return base;
		lowlen = ib - h;
		hmask = SLOT_BITS'((1 << h) - 1);
		lmask = SLOT_BITS'((1 << lowlen) - 1);
		return ((((ghist & hmask) ^ (base >> lowlen)) & hmask) << lowlen) | (base & lmask);
	endfunction

	// Predict one branch item, update model state, queue the expected result
	task automatic predict_branch(input gbp_req_t item);
		int ib;
		int h;
		logic [SLOT_BITS-1:0] slot;
		logic [SLOT_BITS-1:0] hmask;
		gbp_rsp_t want;
		ib = (index_width < 1) ? 1 : (index_width > SLOT_BITS) ? SLOT_BITS : int'(index_width);
		h = (hist_width > ib) ? ib : int'(hist_width);
		slot = table_slot(item.branch_address, ib, h);
		want.predicted_taken = outcome_table[slot];
		want.prediction_correct = 1'b1;
		if (item.opcode == OP_UPDATE) begin
			if (update_total != '1)
				update_total++;
			outcome_table[slot] = item.actual_taken;
			if (h > 0) begin
				hmask = SLOT_BITS'((1 << h) - 1);
				ghist = (((ghist & hmask) >> 1)
					| (SLOT_BITS'(item.actual_taken) << (h - 1))) & hmask;
			end
			if (want.predicted_taken != item.actual_taken) begin
				want.prediction_correct = 1'b0;
				if (miss_total != '1)
					miss_total++;
			end
		end
		want.prediction_count = update_total;
		want.misprediction_count = miss_total;
		expected_rsps.push_back(want);
	endtask

	// Watch config writes, accepted items and accepted results
	always @(posedge clk or negedge arst_n) begin
		gbp_rsp_t want;
		if (!arst_n) begin
			outcome_table = '1;
			ghist = '0;
			update_total = '0;
			miss_total = '0;
			index_width = INDEX_BITS_RST;
			hist_width = HISTORY_BITS_RST;
			expected_rsps.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_INDEX_BITS:   index_width = cfg_wdata;
					CFG_HISTORY_BITS: hist_width = cfg_wdata;
					default: ;
				endcase
			end
			if (req_valid && !req_stall)
				predict_branch(req);
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					$error("result with no item outstanding: %p", rsp);
					fails++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.predicted_taken !== want.predicted_taken) begin
						$error("predicted_taken: expected %0d, got %0d",
							want.predicted_taken, rsp.predicted_taken);
						fails++;
					end
					if (rsp.prediction_correct !== want.prediction_correct) begin
						$error("prediction_correct: expected %0d, got %0d",
							want.prediction_correct, rsp.prediction_correct);
						fails++;
					end
					if (rsp.prediction_count !== want.prediction_count) begin
						$error("prediction_count: expected %0d, got %0d",
							want.prediction_count, rsp.prediction_count);
						fails++;
					end
					if (rsp.misprediction_count !== want.misprediction_count) begin
						$error("misprediction_count: expected %0d, got %0d",
							want.misprediction_count, rsp.misprediction_count);
						fails++;
					end
				end
			end
			pending = expected_rsps.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
// Stimulus, clock, reset and verdict for the gshare branch predictor.
module testbench;
	import gbp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 175;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_INDEX_BITS;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	gbp_req_t             req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	gbp_rsp_t             rsp;

	int  chk_fails;
	int  chk_pending;
	int  cycles = 0;
	int  stall_left = 0;
	bit  idle_on = 1'b1;

	logic [ADDR_W-1:0] loop_addr[8];
	int                loop_bias[8];

	gshare_branch_predictor DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	gbp_result_check result_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.fails     (chk_fails),
		.pending   (chk_pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL gshare_branch_predictor");
			$finish;
		end
	end

	// Result side back-pressure in random bursts while idle_on is set
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			rsp_stall <= 1'b1;
			stall_left = $urandom_range(0, 4);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Offer one branch item, with an occasional gap while idle_on is set, and hold it until accepted
	task automatic send_branch(input logic op, input logic [ADDR_W-1:0] addr,
			input logic taken);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req.opcode <= op;
		req.branch_address <= addr;
		req.actual_taken <= taken;
		forever begin
			@(posedge clk);
			if (!req_stall)
				break;
		end
	endtask

	// Stop sending and wait for every outstanding result
	task automatic drain;
		@(negedge clk);
		req_valid <= 1'b0;
		while (chk_pending != 0)
			@(negedge clk);
	endtask

	task automatic set_config(input logic [CFG_W-1:0] ib, input logic [CFG_W-1:0] hb);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_INDEX_BITS;
		cfg_wdata <= ib;
		@(negedge clk);
		cfg_index <= CFG_HISTORY_BITS;
		cfg_wdata <= hb;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// New set of loop branches near one base address, each with its own bias
	task automatic new_loops;
		logic [ADDR_W-1:0] base;
		base = $urandom;
		foreach (loop_addr[k]) begin
			loop_addr[k] = base + ADDR_W'(4 * $urandom_range(0, 15)) + ADDR_W'($urandom_range(0, 3));
			loop_bias[k] = $urandom_range(0, 100);
		end
	endtask

	initial begin
		int kind;
		int k;
		logic [CFG_W-1:0] ib;
		logic [CFG_W-1:0] hb;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset configuration, address extremes, both ops and outcomes
		idle_on = 1'b0;
		send_branch(OP_UPDATE, 32'h0000_0000, 1'b0);
		send_branch(OP_QUERY,  32'h0000_0000, 1'b1);
		send_branch(OP_QUERY,  32'h0000_0000, 1'b0);
		send_branch(OP_UPDATE, 32'hFFFF_FFFF, 1'b1);
		send_branch(OP_UPDATE, 32'hFFFF_FFFF, 1'b0);
		send_branch(OP_QUERY,  32'hFFFF_FFFF, 1'b0);
		send_branch(OP_UPDATE, 32'h0000_4000, 1'b1);
		send_branch(OP_UPDATE, 32'h0000_3FFC, 1'b0);
		// Index width below range acts as one bit, history clamps to it
		set_config(4'd0, 4'd15);
		send_branch(OP_UPDATE, 32'h0000_0004, 1'b0);
		send_branch(OP_UPDATE, 32'h0000_0004, 1'b1);
		send_branch(OP_QUERY,  32'hFFFF_FFF8, 1'b1);
		// Index width above range, full-width history hashing
		set_config(4'd15, 4'd15);
		send_branch(OP_UPDATE, 32'hAAAA_AAAA, 1'b1);
		send_branch(OP_UPDATE, 32'h5555_5555, 1'b0);
		send_branch(OP_QUERY,  32'hAAAA_AAAA, 1'b0);
		// Hashing off; history upper bits left stale from the last setting
		set_config(4'd12, 4'd0);
		send_branch(OP_UPDATE, 32'h0000_3FFC, 1'b1);
		send_branch(OP_QUERY,  32'h0000_0000, 1'b1);
		// Shorter history after a longer one
		set_config(4'd6, 4'd2);
		send_branch(OP_UPDATE, 32'h1234_5678, 1'b1);
		send_branch(OP_UPDATE, 32'h1234_5678, 1'b0);
		send_branch(OP_QUERY,  32'h1234_5678, 1'b0);

		// Random phases over several settings, loop branches plus noise
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin ib = INDEX_BITS_RST; hb = HISTORY_BITS_RST; end
				1: begin ib = 4'd1;  hb = 4'd0;  end
				2: begin ib = 4'd1;  hb = 4'd1;  end
				3: begin ib = 4'd12; hb = 4'd12; end
				4: begin ib = 4'd15; hb = 4'd3;  end
				5: begin ib = 4'd12; hb = 4'd0;  end
				6: begin ib = 4'd4;  hb = 4'd14; end
				default: begin
					ib = CFG_W'($urandom_range(0, 15));
					hb = CFG_W'($urandom_range(0, 15));
				end
			endcase
			set_config(ib, hb);
			idle_on = (p != 3 && p != PHASES - 1);
			new_loops();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					k = $urandom_range(0, 7);
					send_branch(($urandom_range(0, 7) == 0) ? OP_QUERY : OP_UPDATE,
						loop_addr[k], ($urandom_range(0, 99) < loop_bias[k]));
				end else begin
					send_branch($urandom_range(0, 1) ? OP_QUERY : OP_UPDATE,
						ADDR_W'($urandom), 1'($urandom_range(0, 1)));
				end
				// Hold the sender until the block is empty once, mid-way through the first phase
				if (p == 0 && n == PHASE_ITEMS / 2)
					drain();
				if (n % 40 == 39)
					new_loops();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (chk_fails == 0 && chk_pending == 0)
			$display("PASS gshare_branch_predictor");
		else
			$display("FAIL gshare_branch_predictor");
		$finish;
	end

endmodule
